@@ rtl/dsdsrc_pkg.sv @@
// Shared types, register indexes, reset values and width helpers for the
// diffusion stencil unit with disc source. Used by every file in rtl/ but dsdsrc_ram.
package dsdsrc_pkg;

   // Default line length of the grid interior (top-level parameter default)
   localparam int MAX_COLS_DEF = 64;

   // Fixed row limit and row counter width (counter holds up to ROW_LIMIT+1)
   localparam int ROW_LIMIT = 64;
   localparam int ROW_W     = 7;

   // Field widths
   localparam int CONC_W   = 32;
   localparam int RADIUS_W = 24;
   localparam int GAIN_W   = 16;
   localparam int SRC_W    = 24;
   localparam int CTR_W    = 8;
   localparam int SIZE_W   = 7;
   localparam int LAP_W    = CONC_W + 3;
   localparam int DY_W     = 10;

   // Register map
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SOURCE_ADD  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_COL  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTRE_ROW  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH_RATIO = 3'd7;

   // Register reset values
   localparam logic [SIZE_W-1:0] GRID_COLS_RST   = 7'd49;
   localparam logic [SIZE_W-1:0] GRID_ROWS_RST   = 7'd49;
   localparam logic [GAIN_W-1:0] GAIN_X_RST      = 16'd2458;
   localparam logic [GAIN_W-1:0] GAIN_Y_RST      = 16'd2458;
   localparam logic [SRC_W-1:0]  SOURCE_ADD_RST  = 24'd16777;
   localparam logic [CTR_W-1:0]  CENTRE_COL_RST  = 8'd51;
   localparam logic [CTR_W-1:0]  CENTRE_ROW_RST  = 8'd51;
   localparam logic [GAIN_W-1:0] WIDTH_RATIO_RST = 16'd13107;

   // Column counter width: holds up to max_cols+2
   function automatic int col_width(input int max_cols);
      return $clog2(max_cols + 3);
   endfunction

   // Signed width of the column offset in half cells
   function automatic int dx_width(input int max_cols);
      int w;
      w = col_width(max_cols) + 2;
      return (w > 10) ? w : 10;
   endfunction

   // Stencil word handed from the window to the update datapath
   typedef struct packed {
      logic                last;
      logic [RADIUS_W-1:0] radius;
      logic [CONC_W-1:0]   c;
      logic [LAP_W-1:0]    lx;   // two's complement
      logic [LAP_W-1:0]    ly;   // two's complement
      logic [DY_W-1:0]     dy;   // two's complement, half cells
   } sten_type;

endpackage

@@ rtl/dsdsrc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read-first: a read and write at one address in one cycle returns old data.
module dsdsrc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 66
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/dsdsrc_window.sv @@
// Raster position counters, two line buffers and the stencil window.
// Depends on dsdsrc_pkg and dsdsrc_ram; feeds dsdsrc_update.
module dsdsrc_window #(
   parameter int MAX_COLS = dsdsrc_pkg::MAX_COLS_DEF
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic [dsdsrc_pkg::SIZE_W-1:0]               grid_cols,
   input  logic [dsdsrc_pkg::SIZE_W-1:0]               grid_rows,
   input  logic [dsdsrc_pkg::CTR_W-1:0]                centre_col_half,
   input  logic [dsdsrc_pkg::CTR_W-1:0]                centre_row_half,
   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   input  logic [dsdsrc_pkg::CONC_W-1:0]               req_conc,
   input  logic [dsdsrc_pkg::RADIUS_W-1:0]             req_radius,
   input  logic                                        req_start,
   output logic                                        sten_valid,
   input  logic                                        sten_ready,
   output dsdsrc_pkg::sten_type                        sten,
   output logic [dsdsrc_pkg::dx_width(MAX_COLS)-1:0]   sten_dx
);

   localparam int LINE_LEN = MAX_COLS + 2;
   localparam int AW       = $clog2(LINE_LEN);
   localparam int CW       = dsdsrc_pkg::col_width(MAX_COLS);
   localparam int DXW      = dsdsrc_pkg::dx_width(MAX_COLS);
   localparam int RW       = dsdsrc_pkg::ROW_W;
   localparam int DW       = dsdsrc_pkg::CONC_W;
   localparam int LW       = dsdsrc_pkg::LAP_W;
   localparam int YW       = dsdsrc_pkg::DY_W;

   // Position counters
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [CW-1:0] cols_eff, cols_end, k_a, k_nx, k_inc;
   logic [RW-1:0] rows_eff, rows_end, r_a, r_nx, r_inc;
   logic [AW-1:0] k_addr;
   logic          accept;

   // Line buffer control
   logic [LINE_LEN-1:0] va_ff, va_in, vb_ff, vb_in;
   logic                pend_ff;
   logic [AW-1:0]       pend_addr_ff;
   logic [DW-1:0]       rd_a, rd_b, mid, top;

   // Stage 1
   logic          s1_valid_ff, s1_valid_in;
   logic [DW-1:0] s1_cur_ff;
   logic [dsdsrc_pkg::RADIUS_W-1:0] s1_radius_ff;
   logic [CW-1:0] s1_k_ff;
   logic [RW-1:0] s1_r_ff;
   logic          s1_prod_ff, s1_last_ff;
   logic          va_hit_ff, vb_hit_ff, fwd_ff;
   logic [DW-1:0] fwd_data_ff;
   logic          s1_adv, s2_free;

   // Window
   logic [DW-1:0] w0_ff, w1_ff, w2_ff, w4_ff;

   // Stencil output stage
   logic                   sten_valid_ff, sten_valid_in;
   dsdsrc_pkg::sten_type   sten_ff, sten_in;
   logic [DXW-1:0]         sten_dx_ff, sten_dx_in;

   always_comb begin
      priority if (grid_cols == '0) begin
         cols_eff = CW'(1);
      end else if (32'(grid_cols) > 32'(MAX_COLS)) begin
         cols_eff = CW'(MAX_COLS);
      end else begin
         cols_eff = CW'(grid_cols);
      end
      priority if (grid_rows == '0) begin
         rows_eff = RW'(1);
      end else if (32'(grid_rows) > 32'(dsdsrc_pkg::ROW_LIMIT)) begin
         rows_eff = RW'(dsdsrc_pkg::ROW_LIMIT);
      end else begin
         rows_eff = RW'(grid_rows);
      end
      cols_end = cols_eff + CW'(1);
      rows_end = rows_eff + RW'(1);
   end

   assign accept = req_tvalid & req_tready;

   // Position of the arriving word, then the position of the one after it
   always_comb begin
      k_a = req_start ? '0 : col_ff;
      r_a = req_start ? '0 : row_ff;
      k_nx = k_a;
      r_nx = r_a;
      if (k_a > cols_end) begin
         k_nx = '0;
         r_nx = r_a + RW'(1);
      end
      if (r_nx > rows_end) begin
         r_nx = '0;
      end
      k_inc = k_nx + CW'(1);
      r_inc = r_nx;
      if (k_inc > cols_end) begin
         k_inc = '0;
         r_inc = r_nx + RW'(1);
         if (r_inc > rows_end) begin
            r_inc = '0;
         end
      end
      col_in = accept ? k_inc : col_ff;
      row_in = accept ? r_inc : row_ff;
   end

   assign k_addr = k_nx[AW-1:0];

   // Upper line: takes the word on accept. Lower line: takes the evicted
   // upper-line word in the cycle after the accept, once its read data is out.
   dsdsrc_ram #(.WIDTH(DW), .DEPTH(LINE_LEN)) u_line_a (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (k_addr),
      .wr_data (req_conc),
      .rd_en   (accept),
      .rd_addr (k_addr),
      .rd_data (rd_a)
   );

   dsdsrc_ram #(.WIDTH(DW), .DEPTH(LINE_LEN)) u_line_b (
      .clock   (clock),
      .wr_en   (pend_ff),
      .wr_addr (pend_addr_ff),
      .wr_data (mid),
      .rd_en   (accept),
      .rd_addr (k_addr),
      .rd_data (rd_b)
   );

   // Entries never written read as zero
   assign mid = va_hit_ff ? rd_a : '0;
   assign top = fwd_ff ? fwd_data_ff : (vb_hit_ff ? rd_b : '0);

   always_comb begin
      va_in = va_ff;
      vb_in = vb_ff;
      if (accept) begin
         va_in[k_addr] = 1'b1;
      end
      if (pend_ff) begin
         vb_in[pend_addr_ff] = 1'b1;
      end
   end

   // Stage 1 advance: words without a result only shift the window
   assign s2_free    = !sten_valid_ff || sten_ready;
   assign s1_adv     = s1_valid_ff && (!s1_prod_ff || s2_free);
   assign req_tready = !s1_valid_ff || !s1_prod_ff || s2_free;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      sten_in.last   = s1_last_ff;
      sten_in.radius = s1_radius_ff;
      sten_in.c      = w1_ff;
      sten_in.lx     = LW'(w4_ff) + LW'(mid) - (LW'(w1_ff) << 1);
      sten_in.ly     = LW'(w0_ff) + LW'(w2_ff) - (LW'(w1_ff) << 1);
      sten_in.dy     = (YW'(s1_r_ff) << 1) - YW'(2) - YW'(centre_row_half);
      sten_dx_in     = (DXW'(s1_k_ff) << 1) - DXW'(2) - DXW'(centre_col_half);
      sten_valid_in  = sten_valid_ff;
      if (s1_adv && s1_prod_ff) begin
         sten_valid_in = 1'b1;
      end else if (sten_ready) begin
         sten_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         va_ff         <= '0;
         vb_ff         <= '0;
         pend_ff       <= 1'b0;
         s1_valid_ff   <= 1'b0;
         sten_valid_ff <= 1'b0;
         w0_ff         <= '0;
         w1_ff         <= '0;
         w2_ff         <= '0;
         w4_ff         <= '0;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         va_ff         <= va_in;
         vb_ff         <= vb_in;
         pend_ff       <= accept;
         s1_valid_ff   <= s1_valid_in;
         sten_valid_ff <= sten_valid_in;
         if (s1_adv) begin
            w0_ff <= top;
            w1_ff <= mid;
            w2_ff <= s1_cur_ff;
            w4_ff <= w1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_addr_ff <= k_addr;
         s1_cur_ff    <= req_conc;
         s1_radius_ff <= req_radius;
         s1_k_ff      <= k_nx;
         s1_r_ff      <= r_nx;
         s1_prod_ff   <= (r_nx >= RW'(2)) && (k_nx >= CW'(2));
         s1_last_ff   <= (r_nx == rows_end) && (k_nx == cols_end);
         va_hit_ff    <= va_ff[k_addr];
         vb_hit_ff    <= vb_ff[k_addr];
         // lower-line write still in flight to this address: forward it
         fwd_ff       <= pend_ff && (pend_addr_ff == k_addr);
         fwd_data_ff  <= mid;
      end
      if (s1_adv && s1_prod_ff) begin
         sten_ff    <= sten_in;
         sten_dx_ff <= sten_dx_in;
      end
   end

   assign sten_valid = sten_valid_ff;
   assign sten       = sten_ff;
   assign sten_dx    = sten_dx_ff;

endmodule

@@ rtl/dsdsrc_update.sv @@
// Product stage and result stage of the stencil update: gains, disc and
// stripe tests, rounding and saturation. Depends on dsdsrc_pkg.
module dsdsrc_update #(
   parameter int MAX_COLS = dsdsrc_pkg::MAX_COLS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic [dsdsrc_pkg::GAIN_W-1:0]             gain_x,
   input  logic [dsdsrc_pkg::GAIN_W-1:0]             gain_y,
   input  logic [dsdsrc_pkg::SRC_W-1:0]              source_add,
   input  logic [dsdsrc_pkg::GAIN_W-1:0]             width_ratio,
   input  logic                                      sten_valid,
   output logic                                      sten_ready,
   input  dsdsrc_pkg::sten_type                      sten,
   input  logic [dsdsrc_pkg::dx_width(MAX_COLS)-1:0] sten_dx,
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [dsdsrc_pkg::CONC_W-1:0]             rsp_conc,
   output logic                                      rsp_disc,
   output logic                                      rsp_last
);

   localparam int DXW = dsdsrc_pkg::dx_width(MAX_COLS);
   localparam int D2W = 2 * DXW + 1;
   localparam int EW  = D2W + 32;
   localparam int EW2 = DXW + 32;
   localparam int LW  = dsdsrc_pkg::LAP_W;
   localparam int GW  = dsdsrc_pkg::GAIN_W;
   localparam int PW  = LW + GW + 1;
   localparam int SW  = PW + 2;
   localparam int CW  = dsdsrc_pkg::CONC_W;
   localparam int RW  = dsdsrc_pkg::RADIUS_W;
   localparam int YW  = dsdsrc_pkg::DY_W;

   // Product stage
   logic                p_valid_ff, p_valid_in;
   logic signed [PW-1:0] p_gx_ff, p_gy_ff, gx_prod, gy_prod;
   logic [2*RW-1:0]     p_rr_ff, rr_prod;
   logic [GW+RW-1:0]    p_wr_ff, wr_prod;
   logic [D2W-1:0]      p_d2_ff, d2;
   logic [DXW-1:0]      p_adx_ff, adx;
   logic [CW-1:0]       p_c_ff;
   logic                p_last_ff;
   logic signed [2*DXW-1:0] dx_sq;
   logic signed [2*YW-1:0]  dy_sq;
   logic signed [DXW-1:0]   dx_s;
   logic signed [YW-1:0]    dy_s;

   // Result stage
   logic                 out_free, p_go;
   logic                 rsp_tvalid_ff, rsp_tvalid_in;
   logic [CW-1:0]        rsp_conc_ff, conc_in;
   logic                 rsp_disc_ff, rsp_last_ff;
   logic                 disc_hit, stripe;
   logic signed [SW-1:0] sum, rsum;
   logic [SW-17:0]       rs;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign sten_ready = !p_valid_ff || out_free;
   assign p_go       = p_valid_ff && out_free;

   always_comb begin
      dx_s    = $signed(sten_dx);
      dy_s    = $signed(sten.dy);
      gx_prod = $signed({{(PW-GW){1'b0}}, gain_x})
              * $signed({{(PW-LW){sten.lx[LW-1]}}, sten.lx});
      gy_prod = $signed({{(PW-GW){1'b0}}, gain_y})
              * $signed({{(PW-LW){sten.ly[LW-1]}}, sten.ly});
      rr_prod = (2*RW)'(sten.radius) * (2*RW)'(sten.radius);
      wr_prod = (GW+RW)'(width_ratio) * (GW+RW)'(sten.radius);
      dx_sq   = (2*DXW)'(dx_s) * (2*DXW)'(dx_s);
      dy_sq   = (2*YW)'(dy_s) * (2*YW)'(dy_s);
      d2      = D2W'(unsigned'(dx_sq)) + D2W'(unsigned'(dy_sq));
      adx     = dx_s[DXW-1] ? DXW'(-dx_s) : unsigned'(dx_s);
      p_valid_in = p_valid_ff;
      if (sten_valid && sten_ready) begin
         p_valid_in = 1'b1;
      end else if (out_free) begin
         p_valid_in = 1'b0;
      end
   end

   // Disc and stripe tests, sum with source, round half up, saturate
   always_comb begin
      disc_hit = ((EW'(p_d2_ff)) << 32) < EW'(p_rr_ff);
      stripe   = ((EW2'(p_adx_ff)) << 32) < EW2'(p_wr_ff);
      sum    = $signed({{(SW-CW-16){1'b0}}, p_c_ff, 16'b0})
             + $signed({{(SW-PW){p_gx_ff[PW-1]}}, p_gx_ff})
             + $signed({{(SW-PW){p_gy_ff[PW-1]}}, p_gy_ff});
      if (disc_hit && stripe) begin
         sum = sum + $signed({{(SW-dsdsrc_pkg::SRC_W-16){1'b0}}, source_add, 16'b0});
      end
      rsum = sum + SW'(32768);
      rs   = rsum[SW-1:16];
      priority if (sum[SW-1]) begin
         conc_in = '0;
      end else if (|rs[SW-17:CW]) begin
         conc_in = '1;
      end else begin
         conc_in = rs[CW-1:0];
      end
      rsp_tvalid_in = rsp_tvalid_ff;
      if (p_go) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         p_valid_ff    <= p_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sten_valid && sten_ready) begin
         p_gx_ff   <= gx_prod;
         p_gy_ff   <= gy_prod;
         p_rr_ff   <= rr_prod;
         p_wr_ff   <= wr_prod;
         p_d2_ff   <= d2;
         p_adx_ff  <= adx;
         p_c_ff    <= sten.c;
         p_last_ff <= sten.last;
      end
      if (p_go) begin
         rsp_conc_ff <= conc_in;
         rsp_disc_ff <= disc_hit;
         rsp_last_ff <= p_last_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_conc   = rsp_conc_ff;
   assign rsp_disc   = rsp_disc_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ rtl/diffusion_stencil_disc_source_unit.sv @@
// Top level of the diffusion stencil unit with disc source: register file,
// window/line-buffer front end and update datapath. Depends on dsdsrc_pkg,
// dsdsrc_window and dsdsrc_update.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  tdata: old_conc, radius; tuser: frame_start
//   rsp      out  rsp_tvalid/rsp_tready  tdata: new_conc; tuser: in_disc; tlast: frame_last
//   csr      in   csr_valid/csr_ready    csr_index, csr_wdata (register write)
//
// One word is taken per cycle unless a stall on rsp holds it. The word that completes
// a stencil leaves its result via line-buffer read, window, gain products and sum.
// Words in the first two rows or the first two columns of a frame give no
// result; every other word completes the cell one row up and one column back.
// Reset clears the position, the window and the line-buffer valid bits and
// loads the register defaults; no clearing pass is needed.
// A stall on rsp holds the pipeline stage by stage; words without a result
// keep flowing into the window while earlier results wait.
module diffusion_stencil_disc_source_unit #(
   parameter int MAX_COLS = dsdsrc_pkg::MAX_COLS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // stream in
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [55:0]                          req_tdata,  // [31:0] old_conc, [55:32] radius
   input  logic                                 req_tuser,  // [0] frame_start
   // stream out
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [31:0]                          rsp_tdata,  // [31:0] new_conc
   output logic                                 rsp_tuser,  // [0] in_disc
   output logic                                 rsp_tlast,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dsdsrc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dsdsrc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int DXW = dsdsrc_pkg::dx_width(MAX_COLS);

   // Register file
   logic [dsdsrc_pkg::SIZE_W-1:0] grid_cols_ff, grid_rows_ff;
   logic [dsdsrc_pkg::GAIN_W-1:0] gain_x_ff, gain_y_ff, width_ratio_ff;
   logic [dsdsrc_pkg::SRC_W-1:0]  source_add_ff;
   logic [dsdsrc_pkg::CTR_W-1:0]  centre_col_ff, centre_row_ff;

   // Window to update datapath
   logic                 sten_valid, sten_ready;
   dsdsrc_pkg::sten_type sten;
   logic [DXW-1:0]       sten_dx;

   // Always ready; writes must land while the block is idle, which it does not enforce
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff   <= dsdsrc_pkg::GRID_COLS_RST;
         grid_rows_ff   <= dsdsrc_pkg::GRID_ROWS_RST;
         gain_x_ff      <= dsdsrc_pkg::GAIN_X_RST;
         gain_y_ff      <= dsdsrc_pkg::GAIN_Y_RST;
         source_add_ff  <= dsdsrc_pkg::SOURCE_ADD_RST;
         centre_col_ff  <= dsdsrc_pkg::CENTRE_COL_RST;
         centre_row_ff  <= dsdsrc_pkg::CENTRE_ROW_RST;
         width_ratio_ff <= dsdsrc_pkg::WIDTH_RATIO_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dsdsrc_pkg::CSR_GRID_COLS:   grid_cols_ff   <= csr_wdata[dsdsrc_pkg::SIZE_W-1:0];
            dsdsrc_pkg::CSR_GRID_ROWS:   grid_rows_ff   <= csr_wdata[dsdsrc_pkg::SIZE_W-1:0];
            dsdsrc_pkg::CSR_GAIN_X:      gain_x_ff      <= csr_wdata[dsdsrc_pkg::GAIN_W-1:0];
            dsdsrc_pkg::CSR_GAIN_Y:      gain_y_ff      <= csr_wdata[dsdsrc_pkg::GAIN_W-1:0];
            dsdsrc_pkg::CSR_SOURCE_ADD:  source_add_ff  <= csr_wdata[dsdsrc_pkg::SRC_W-1:0];
            dsdsrc_pkg::CSR_CENTRE_COL:  centre_col_ff  <= csr_wdata[dsdsrc_pkg::CTR_W-1:0];
            dsdsrc_pkg::CSR_CENTRE_ROW:  centre_row_ff  <= csr_wdata[dsdsrc_pkg::CTR_W-1:0];
            dsdsrc_pkg::CSR_WIDTH_RATIO: width_ratio_ff <= csr_wdata[dsdsrc_pkg::GAIN_W-1:0];
         endcase
      end
   end

   // Position tracking, line buffers and the 3x2 window
   dsdsrc_window #(.MAX_COLS(MAX_COLS)) u_window (
      .clock           (clock),
      .reset           (reset),
      .grid_cols       (grid_cols_ff),
      .grid_rows       (grid_rows_ff),
      .centre_col_half (centre_col_ff),
      .centre_row_half (centre_row_ff),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_conc        (req_tdata[31:0]),
      .req_radius      (req_tdata[55:32]),
      .req_start       (req_tuser),
      .sten_valid      (sten_valid),
      .sten_ready      (sten_ready),
      .sten            (sten),
      .sten_dx         (sten_dx)
   );

   // Gain products, disc test, sum and saturation
   dsdsrc_update #(.MAX_COLS(MAX_COLS)) u_update (
      .clock       (clock),
      .reset       (reset),
      .gain_x      (gain_x_ff),
      .gain_y      (gain_y_ff),
      .source_add  (source_add_ff),
      .width_ratio (width_ratio_ff),
      .sten_valid  (sten_valid),
      .sten_ready  (sten_ready),
      .sten        (sten),
      .sten_dx     (sten_dx),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_conc    (rsp_tdata),
      .rsp_disc    (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

endmodule

@@ bench/tb.sv @@
// Self-checking bench for diffusion_stencil_disc_source_unit: streams halo-framed grids
// through the block and compares each updated interior cell with a local stencil predictor.
// Depends on dsdsrc_pkg and the rtl/ sources of the unit.
`timescale 1ns / 1ps

module tb;

   localparam int MAX_COLS    = dsdsrc_pkg::MAX_COLS_DEF;
   localparam int LINE_LEN    = MAX_COLS + 2;
   localparam int ROW_LIMIT   = dsdsrc_pkg::ROW_LIMIT;
   localparam int CONC_W      = dsdsrc_pkg::CONC_W;
   localparam int RADIUS_W    = dsdsrc_pkg::RADIUS_W;
   localparam int SIZE_W      = dsdsrc_pkg::SIZE_W;
   localparam int GAIN_W      = dsdsrc_pkg::GAIN_W;
   localparam int SRC_W       = dsdsrc_pkg::SRC_W;
   localparam int CTR_W       = dsdsrc_pkg::CTR_W;
   localparam int CSR_IDX_W   = dsdsrc_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = dsdsrc_pkg::CSR_DATA_W;
   // Cycles with no word moved on any channel before the run is abandoned
   localparam int QUIET_LIMIT = 2000;

   // One predicted interior update
   typedef struct packed {
      logic [CONC_W-1:0] conc;
      logic              in_disc;
      logic              last;
   } stencil_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [55:0]           req_tdata  = '0;   // [31:0] old_conc, [55:32] radius
   logic                  req_tuser  = 1'b0; // [0] frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;         // [31:0] new_conc
   logic                  rsp_tuser;         // [0] in_disc
   logic                  rsp_tlast;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // Predictor copy of the register file, reset to the block's defaults
   logic [SIZE_W-1:0] cfg_cols  = dsdsrc_pkg::GRID_COLS_RST;
   logic [SIZE_W-1:0] cfg_rows  = dsdsrc_pkg::GRID_ROWS_RST;
   logic [GAIN_W-1:0] cfg_gx    = dsdsrc_pkg::GAIN_X_RST;
   logic [GAIN_W-1:0] cfg_gy    = dsdsrc_pkg::GAIN_Y_RST;
   logic [SRC_W-1:0]  cfg_src   = dsdsrc_pkg::SOURCE_ADD_RST;
   logic [CTR_W-1:0]  cfg_ccol  = dsdsrc_pkg::CENTRE_COL_RST;
   logic [CTR_W-1:0]  cfg_crow  = dsdsrc_pkg::CENTRE_ROW_RST;
   logic [GAIN_W-1:0] cfg_ratio = dsdsrc_pkg::WIDTH_RATIO_RST;

   // Predictor copy of the line buffers, the 3x2 window and the raster position
   logic [CONC_W-1:0] line_copy [0:2*LINE_LEN-1];
   logic [CONC_W-1:0] win_copy  [0:5];
   int pos_col = 0;
   int pos_row = 0;

   stencil_result_type pending_updates [$];
   int  error_count = 0;
   int  sent_words  = 0;
   bit  idle_on     = 1'b0;

   diffusion_stencil_disc_source_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Grid size as the block uses it: zero counts as one, oversize is clipped
   function automatic int grid_span(input int unsigned raw, input int limit);
      if (raw == 0) return 1;
      if (raw > limit) return limit;
      return int'(raw);
   endfunction

   // Mostly moderate gains so results stay in range, now and then the extremes
   function automatic int unsigned pick_gain();
      case ($urandom_range(0, 9))
         0:       return 0;
         1:       return 16'hFFFF;
         2:       return $urandom_range(0, 16'hFFFF);
         default: return $urandom_range(0, 16383);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s: got %h, expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Work out the update caused by one accepted word, mirroring the block's raster walk
   task automatic predict_update(input logic [CONC_W-1:0] cur,
                                 input logic [RADIUS_W-1:0] rad,
                                 input bit frame_start);
      int cols, rows, k, r, ccol, crow;
      logic [CONC_W-1:0] top, mid;
      longint cv, ev, wv, nv, sv, lx, ly, dxh, dyh, gxv, gyv, srcv, sum;
      longint unsigned d2, adx, rad64, ratio64, res;
      bit in_circle, in_strip;
      stencil_result_type upd;
      cols = grid_span(32'(cfg_cols), MAX_COLS);
      rows = grid_span(32'(cfg_rows), ROW_LIMIT);
      // Restart on a frame start; wrap a position left stale by a size change
      if (frame_start) begin
         pos_col = 0;
         pos_row = 0;
      end
      if (pos_col > cols + 1) begin
         pos_col = 0;
         pos_row++;
      end
      if (pos_row > rows + 1) pos_row = 0;
      k = pos_col;
      r = pos_row;

      top = line_copy[LINE_LEN + k];
      mid = line_copy[k];
      line_copy[LINE_LEN + k] = mid;
      line_copy[k] = cur;

      // The word at column k completes the stencil of the cell one column back
      if (r >= 2 && k >= 2) begin
         cv = longint'(win_copy[1]);
         wv = longint'(win_copy[4]);
         ev = longint'(mid);
         nv = longint'(win_copy[0]);
         sv = longint'(win_copy[2]);
         lx = wv + ev - 2 * cv;
         ly = nv + sv - 2 * cv;
         ccol = int'(cfg_ccol);
         crow = int'(cfg_crow);
         dxh = longint'(2 * (k - 1) - ccol);
         dyh = longint'(2 * (r - 1) - crow);
         d2 = unsigned'(dxh * dxh + dyh * dyh);
         adx = unsigned'((dxh < 0) ? -dxh : dxh);
         rad64 = 64'(rad);
         ratio64 = 64'(cfg_ratio);
         in_circle = (d2 << 32) < rad64 * rad64;
         in_strip = (adx << 32) < ratio64 * rad64;
         gxv = longint'(cfg_gx);
         gyv = longint'(cfg_gy);
         srcv = longint'(cfg_src);
         sum = (cv << 16) + gxv * lx + gyv * ly;
         if (in_circle && in_strip) sum += srcv << 16;
         // Round half up, then clamp to the unsigned range
         if (sum < 0) begin
            res = 0;
         end else begin
            res = unsigned'(sum + 32768) >> 16;
            if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
         end
         upd.conc = res[31:0];
         upd.in_disc = in_circle;
         upd.last = (r == rows + 1) && (k == cols + 1);
         pending_updates.push_back(upd);
      end

      win_copy[3] = win_copy[0];
      win_copy[4] = win_copy[1];
      win_copy[5] = win_copy[2];
      win_copy[0] = top;
      win_copy[1] = mid;
      win_copy[2] = cur;

      pos_col++;
      if (pos_col > cols + 1) begin
         pos_col = 0;
         pos_row++;
         if (pos_row > rows + 1) pos_row = 0;
      end
   endtask

   // Write one register, with random junk above the field now and then
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int unsigned value);
      logic [47:0] wword, junk;
      int width;
      case (idx)
         dsdsrc_pkg::CSR_GRID_COLS, dsdsrc_pkg::CSR_GRID_ROWS:   width = SIZE_W;
         dsdsrc_pkg::CSR_GAIN_X, dsdsrc_pkg::CSR_GAIN_Y,
         dsdsrc_pkg::CSR_WIDTH_RATIO:                            width = GAIN_W;
         dsdsrc_pkg::CSR_CENTRE_COL, dsdsrc_pkg::CSR_CENTRE_ROW: width = CTR_W;
         default:                                                width = SRC_W;
      endcase
      wword = 48'(value);
      junk = 48'($urandom);
      if ($urandom_range(0, 1) == 1) wword = wword | (junk << width);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= wword[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         dsdsrc_pkg::CSR_GRID_COLS:   cfg_cols  = wword[SIZE_W-1:0];
         dsdsrc_pkg::CSR_GRID_ROWS:   cfg_rows  = wword[SIZE_W-1:0];
         dsdsrc_pkg::CSR_GAIN_X:      cfg_gx    = wword[GAIN_W-1:0];
         dsdsrc_pkg::CSR_GAIN_Y:      cfg_gy    = wword[GAIN_W-1:0];
         dsdsrc_pkg::CSR_SOURCE_ADD:  cfg_src   = wword[SRC_W-1:0];
         dsdsrc_pkg::CSR_CENTRE_COL:  cfg_ccol  = wword[CTR_W-1:0];
         dsdsrc_pkg::CSR_CENTRE_ROW:  cfg_crow  = wword[CTR_W-1:0];
         dsdsrc_pkg::CSR_WIDTH_RATIO: cfg_ratio = wword[GAIN_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      // Let valid sit low between writes so it never drops and rises in one step
      @(posedge clock);
   endtask

   task automatic configure_all(input int unsigned cols, input int unsigned rows,
                                input int unsigned gx, input int unsigned gy,
                                input int unsigned src, input int unsigned ccol,
                                input int unsigned crow, input int unsigned ratio);
      write_reg(dsdsrc_pkg::CSR_GRID_COLS, cols);
      write_reg(dsdsrc_pkg::CSR_GRID_ROWS, rows);
      write_reg(dsdsrc_pkg::CSR_GAIN_X, gx);
      write_reg(dsdsrc_pkg::CSR_GAIN_Y, gy);
      write_reg(dsdsrc_pkg::CSR_SOURCE_ADD, src);
      write_reg(dsdsrc_pkg::CSR_CENTRE_COL, ccol);
      write_reg(dsdsrc_pkg::CSR_CENTRE_ROW, crow);
      write_reg(dsdsrc_pkg::CSR_WIDTH_RATIO, ratio);
   endtask

   // Offer one grid word, optionally after an idle burst, and predict it once taken
   task automatic send_cell(input logic [CONC_W-1:0] conc, input logic [RADIUS_W-1:0] rad,
                            input bit frame_start);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rad, conc};
      req_tuser  <= frame_start;
      do @(posedge clock); while (!req_tready);
      predict_update(conc, rad, frame_start);
      sent_words++;
   endtask

   // Hold the sender until every update is out, then idle before the next phase
   task automatic settle_block();
      req_tvalid <= 1'b0;
      repeat (4) @(posedge clock);
      while (pending_updates.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Stream n words of a frame: a smooth field around a random level, with spikes,
   // zeros, full-scale words and the odd stray frame start mixed in
   task automatic send_frame(input int n_words, input bit with_start);
      logic [CONC_W-1:0]   base, conc;
      logic [RADIUS_W-1:0] rad, word_rad;
      int spread;
      base = $urandom;
      spread = $urandom_range(4, 24);
      case ($urandom_range(0, 5))
         0:       rad = '0;
         1:       rad = RADIUS_W'($urandom);
         default: rad = RADIUS_W'($urandom_range(0, 24 << 16));
      endcase
      for (int i = 0; i < n_words; i++) begin
         case ($urandom_range(0, 9))
            0:       conc = $urandom;
            1:       conc = '0;
            2:       conc = '1;
            default: conc = base + ($urandom & ((32'd1 << spread) - 1));
         endcase
         word_rad = ($urandom_range(0, 9) == 0) ? RADIUS_W'($urandom) : rad;
         send_cell(conc, word_rad, (i == 0) ? with_start : ($urandom_range(0, 299) == 0));
      end
   endtask

   // 1x1 interior: one frame drives the sum negative, the next (entered by wrapping,
   // no frame start) drives it above full scale with a zero radius
   task automatic test_saturation_corners();
      idle_on = 1'b1;
      configure_all(1, 1, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 2, 2, 16'hFFFF);
      for (int i = 0; i < 9; i++)
         send_cell((i == 4) ? 32'hFFFF_FFFF : 32'h0, 24'hFF_FFFF, i == 0);
      for (int i = 0; i < 9; i++)
         send_cell((i == 4) ? 32'h0 : 32'hFFFF_FFFF, 24'h0, 1'b0);
      settle_block();
   endtask

   // Size registers at and beyond their limits, other registers at their extremes at first
   task automatic test_grid_limits();
      idle_on = 1'b1;
      configure_all(127, 0, 0, 0, 0, 0, 255, 0);
      send_frame(LINE_LEN * 3, 1'b1);
      settle_block();
      configure_all(0, 127, 16'hFFFF, 16'hFFFF, 24'hFF_FFFF, 255, 0, 16'hFFFF);
      send_frame(3 * (ROW_LIMIT + 2), 1'b1);
      settle_block();
      // Leave this one part way; the next phase may pick up mid-frame at a new size
      configure_all(MAX_COLS, ROW_LIMIT, 4096, 4096, 1 << 16, 64, 64, 32768);
      send_frame(100, 1'b1);
      settle_block();
   endtask

   // Random settings per phase; frames may be cut short or begin without a frame start
   task automatic test_random_frames(input int target);
      int unsigned cols_raw, rows_raw, src, ccol, crow, ratio;
      int cols_e, rows_e, n, frames, stop_at;
      stop_at = sent_words + target;
      while (sent_words < stop_at) begin
         idle_on = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 11))
            0:       cols_raw = 0;
            1:       cols_raw = $urandom_range(MAX_COLS + 1, 127);
            2:       cols_raw = MAX_COLS;
            default: cols_raw = $urandom_range(1, 6);
         endcase
         cols_e = grid_span(cols_raw, MAX_COLS);
         if (cols_e > 8)
            rows_raw = $urandom_range(0, 2);
         else
            rows_raw = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 5);
         rows_e = grid_span(rows_raw, ROW_LIMIT);
         src  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 24'hFF_FFFF)
                                             : $urandom_range(0, 1 << 20);
         ccol = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, 2 * cols_e + 4);
         crow = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                             : $urandom_range(0, 2 * rows_e + 4);
         ratio = ($urandom_range(0, 7) == 0) ? 16'hFFFF : $urandom_range(0, 16'hFFFF);
         configure_all(cols_raw, rows_raw, pick_gain(), pick_gain(), src, ccol, crow, ratio);
         frames = (cols_e > 8) ? 1 : $urandom_range(1, 2);
         repeat (frames) begin
            n = (rows_e + 2) * (cols_e + 2);
            if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
            send_frame(n, $urandom_range(0, 5) != 0);
         end
         settle_block();
      end
   endtask

   // Back-to-back words with both sides always ready
   task automatic test_steady_stream();
      idle_on = 1'b0;
      configure_all(4, 4, 3000, 5000, 1 << 18, 5, 5, 40000);
      repeat (2) send_frame(36, 1'b1);
   endtask

   // Response side: ready drops in random bursts while idling is on
   int stall_left = 0;
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 13) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Compare every accepted result word with the oldest pending update
   always @(posedge clock) begin : result_check
      stencil_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_updates.size() == 0) begin
            report_mismatch("result word with no update pending", rsp_tdata, '0);
         end else begin
            want = pending_updates.pop_front();
            if (rsp_tdata !== want.conc)
               report_mismatch("new_conc", rsp_tdata, want.conc);
            if (rsp_tuser !== want.in_disc)
               report_mismatch("in_disc", {31'd0, rsp_tuser}, {31'd0, want.in_disc});
            if (rsp_tlast !== want.last)
               report_mismatch("frame_last", {31'd0, rsp_tlast}, {31'd0, want.last});
         end
      end
   end

   // Abandon the run if no word moves on any channel for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      for (int i = 0; i < 2 * LINE_LEN; i++) line_copy[i] = '0;
      for (int i = 0; i < 6; i++) win_copy[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_saturation_corners();
      test_grid_limits();
      test_random_frames(150);
      test_steady_stream();

      settle_block();
      if (error_count == 0 && pending_updates.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/dsdsrc_pkg.sv
rtl/dsdsrc_ram.sv
rtl/dsdsrc_window.sv
rtl/dsdsrc_update.sv
rtl/diffusion_stencil_disc_source_unit.sv
bench/tb.sv
